// ===== hw/rtl/image_psnr_compare_macros.svh =====
// ----------------------------------------------------------------------------
// image_psnr_compare assertion macros
// Shared property shapes for the PSNR compare block.
// ----------------------------------------------------------------------------
`ifndef IMAGE_PSNR_COMPARE_MACROS_SVH
`define IMAGE_PSNR_COMPARE_MACROS_SVH

// same-cycle implication
`define IPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipc: same-cycle check failed");

// next-cycle implication
`define IPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipc: next-cycle check failed");

`endif

// ===== hw/rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Constants and helpers shared by the PSNR compare block.
// ----------------------------------------------------------------------------
package ipc_pkg;

   localparam int MAX_PIXELS_LOG2_DEF = 20;
   localparam int PSNR_FRAC_BITS_DEF  = 8;

   localparam int SUM_W   = 36;
   localparam int PSNR_W  = 16;
   localparam int FRAME_W = 21;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   localparam logic [PSNR_W-1:0] THRESH_RESET = 16'd6400;

   // BT.601 in Q14
   localparam logic [13:0] GRAY_R   = 14'd4899;
   localparam logic [13:0] GRAY_G   = 14'd9617;
   localparam logic [13:0] GRAY_B   = 14'd1868;
   localparam logic [13:0] GRAY_RND = 14'd8192;

   localparam logic [15:0] PEAK_SQ        = 16'd65025;
   localparam logic [17:0] TEN_LOG10_2    = 18'd197283;

   // log2 unit
   localparam int LOG_W      = 64;
   localparam int LOG_SH_W   = 6;
   localparam int NORM_STEPS = 6;
   localparam int LOG_FRAC   = 16;
   localparam int LOG_RES_W  = LOG_SH_W + LOG_FRAC;
   localparam int MANT_W     = 31;
   localparam int CNT_W      = 4;
   localparam int PROD_W     = 42;

   function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r);
      logic [21:0] acc;
      acc = 22'(r) * 22'(GRAY_R) + 22'(g) * 22'(GRAY_G) + 22'(b) * 22'(GRAY_B)
            + 22'(GRAY_RND);
      return acc[21:14];
   endfunction

endpackage

// ===== hw/rtl/image_psnr_compare.sv =====
// ----------------------------------------------------------------------------
// image_psnr_compare
// Grayscale PSNR between two pixel streams, one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one pixel pair per item (BGR bytes of each image) plus req_last on
//   the final pair of a frame. Pairs are taken one per clock; req_ready drops
//   only when a frame end finds both queue entries busy.
//   rsp_*: one item per frame: PSNR in unsigned Q8.8 dB, match against the
//   threshold register, identical flag (zero error, PSNR saturated), and the
//   pixel count.
//   Path from the last pair: 2 front stages, queue, then two log2 evaluations
//   of 6 normalize + 16 squaring steps each on one 31x31 multiplier, scale
//   and round; identical frames skip the log2, scale and round steps. The
//   shared log2 unit sets the frame rate when frames are very short.
//   A stalled rsp_ready holds the result; the back end waits, the queue
//   fills, and then req_ready drops.
//   Reset clears the accumulators, queue and result valid, and loads the
//   threshold with 25 dB.
//   APB: threshold at address 0, pready always high.
// ----------------------------------------------------------------------------
module image_psnr_compare #(
   parameter int MAX_PIXELS_LOG2 = ipc_pkg::MAX_PIXELS_LOG2_DEF,
   parameter int PSNR_FRAC_BITS  = ipc_pkg::PSNR_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_a_blue,
   input  logic [7:0]                  req_a_green,
   input  logic [7:0]                  req_a_red,
   input  logic [7:0]                  req_b_blue,
   input  logic [7:0]                  req_b_green,
   input  logic [7:0]                  req_b_red,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ipc_pkg::PSNR_W-1:0]  rsp_psnr_db,
   output logic                        rsp_match,
   output logic                        rsp_identical,
   output logic [ipc_pkg::FRAME_W-1:0] rsp_frame_pixels,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ipc_pkg::ADDR_W-1:0]  paddr,
   input  logic [ipc_pkg::CSR_W-1:0]   pwdata,
   output logic [ipc_pkg::CSR_W-1:0]   prdata,
   output logic                        pready
);

   localparam int TallyW = MAX_PIXELS_LOG2 + 1;
   localparam int JobW   = ipc_pkg::SUM_W + TallyW;

   logic [ipc_pkg::PSNR_W-1:0] thresh_ff, thresh_in;
   logic                       csr_sel0;

   logic                       job_push, job_full, job_pop, job_empty;
   logic [ipc_pkg::SUM_W-1:0]  push_sum;
   logic [TallyW-1:0]          push_tally;
   logic [JobW-1:0]            q_din, q_dout;

   assign pready   = 1'b1;
   assign csr_sel0 = (paddr[ipc_pkg::ADDR_W-1] == 1'b0);

   always_comb begin
      thresh_in = thresh_ff;
      if (psel && penable && pwrite && csr_sel0) begin
         thresh_in = pwdata[ipc_pkg::PSNR_W-1:0];
      end
      prdata = csr_sel0 ? ipc_pkg::CSR_W'(thresh_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ipc_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   ipc_front #(
      .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
      .TALLY_W         (TallyW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_a_blue  (req_a_blue),
      .req_a_green (req_a_green),
      .req_a_red   (req_a_red),
      .req_b_blue  (req_b_blue),
      .req_b_green (req_b_green),
      .req_b_red   (req_b_red),
      .req_last    (req_last),
      .job_full    (job_full),
      .job_push    (job_push),
      .job_sum     (push_sum),
      .job_tally   (push_tally)
   );

   assign q_din = {push_sum, push_tally};

   ipc_queue #(
      .DATA_W (JobW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (q_din),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (q_dout),
      .empty (job_empty)
   );

   ipc_back #(
      .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
      .PSNR_FRAC_BITS  (PSNR_FRAC_BITS),
      .TALLY_W         (TallyW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (!job_empty),
      .job_sum          (q_dout[JobW-1:TallyW]),
      .job_tally        (q_dout[TallyW-1:0]),
      .job_pop          (job_pop),
      .match_threshold  (thresh_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_psnr_db      (rsp_psnr_db),
      .rsp_match        (rsp_match),
      .rsp_identical    (rsp_identical),
      .rsp_frame_pixels (rsp_frame_pixels)
   );

endmodule

// ===== hw/rtl/ipc_front.sv =====
// ----------------------------------------------------------------------------
// ipc_front
// Gray conversion, squared difference and per-frame accumulation; hands one
// job per frame to the queue.
// ----------------------------------------------------------------------------
module ipc_front #(
   parameter int MAX_PIXELS_LOG2 = ipc_pkg::MAX_PIXELS_LOG2_DEF,
   parameter int TALLY_W         = MAX_PIXELS_LOG2 + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_a_blue,
   input  logic [7:0]                req_a_green,
   input  logic [7:0]                req_a_red,
   input  logic [7:0]                req_b_blue,
   input  logic [7:0]                req_b_green,
   input  logic [7:0]                req_b_red,
   input  logic                      req_last,
   input  logic                      job_full,
   output logic                      job_push,
   output logic [ipc_pkg::SUM_W-1:0] job_sum,
   output logic [TALLY_W-1:0]        job_tally
);
`include "image_psnr_compare_macros.svh"

   localparam logic [TALLY_W-1:0] TallyMax = TALLY_W'(1) << MAX_PIXELS_LOG2;

   logic                      s1_valid_ff, s1_valid_in;
   logic [7:0]                s1_diff_ff, s1_diff_in;
   logic                      s1_last_ff, s1_last_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic [15:0]               s2_sq_ff, s2_sq_in;
   logic                      s2_last_ff, s2_last_in;
   logic [ipc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [TALLY_W-1:0]        tally_ff, tally_in;

   logic                      adv;
   logic [7:0]                gray_a, gray_b;
   logic [ipc_pkg::SUM_W:0]   sum_add;
   logic [ipc_pkg::SUM_W-1:0] sum_nx;
   logic [TALLY_W-1:0]        tally_nx;

   // whole pipe halts only when a frame end meets a full queue
   assign adv       = !(s2_valid_ff && s2_last_ff && job_full);
   assign req_ready = adv;

   always_comb begin
      gray_a     = ipc_pkg::gray_of(req_a_blue, req_a_green, req_a_red);
      gray_b     = ipc_pkg::gray_of(req_b_blue, req_b_green, req_b_red);
      s1_diff_in = (gray_a > gray_b) ? gray_a - gray_b : gray_b - gray_a;
      s1_last_in = req_last;
      s1_valid_in = adv ? req_valid : s1_valid_ff;

      s2_sq_in    = 16'(s1_diff_ff) * 16'(s1_diff_ff);
      s2_last_in  = s1_last_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

      sum_add = {1'b0, sum_ff} + (ipc_pkg::SUM_W + 1)'(s2_sq_ff);
      if (tally_ff < TallyMax) begin
         tally_nx = tally_ff + TALLY_W'(1);
         sum_nx   = sum_add[ipc_pkg::SUM_W] ? '1 : sum_add[ipc_pkg::SUM_W-1:0];
      end else begin
         tally_nx = tally_ff;
         sum_nx   = sum_ff;
      end

      job_push  = adv && s2_valid_ff && s2_last_ff;
      job_sum   = sum_nx;
      job_tally = tally_nx;

      sum_in   = sum_ff;
      tally_in = tally_ff;
      if (adv && s2_valid_ff) begin
         if (s2_last_ff) begin
            sum_in   = '0;
            tally_in = '0;
         end else begin
            sum_in   = sum_nx;
            tally_in = tally_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         tally_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         tally_ff    <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_diff_ff <= s1_diff_in;
         s1_last_ff <= s1_last_in;
         s2_sq_ff   <= s2_sq_in;
         s2_last_ff <= s2_last_in;
      end
   end

   `IPC_ASSERT_NOW(a_tally_bound, clock, reset, 1'b1, tally_ff <= TallyMax)
   `IPC_ASSERT_NEXT(a_frame_clear, clock, reset, job_push, (sum_ff == '0) && (tally_ff == '0))

endmodule

// ===== hw/rtl/ipc_queue.sv =====
// ----------------------------------------------------------------------------
// ipc_queue
// Two-entry job queue between accumulation and the PSNR back end.
// ----------------------------------------------------------------------------
module ipc_queue #(
   parameter int DATA_W = ipc_pkg::SUM_W + ipc_pkg::MAX_PIXELS_LOG2_DEF + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] din,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] dout,
   output logic              empty
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      full  = (count_ff == 2'd2);
      empty = (count_ff == 2'd0);
      dout  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== hw/rtl/ipc_back.sv =====
// ----------------------------------------------------------------------------
// ipc_back
// Per-frame PSNR: two iterative log2 evaluations, scale, round, result register.
// ----------------------------------------------------------------------------
module ipc_back #(
   parameter int MAX_PIXELS_LOG2 = ipc_pkg::MAX_PIXELS_LOG2_DEF,
   parameter int PSNR_FRAC_BITS  = ipc_pkg::PSNR_FRAC_BITS_DEF,
   parameter int TALLY_W         = MAX_PIXELS_LOG2 + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  logic [ipc_pkg::SUM_W-1:0]   job_sum,
   input  logic [TALLY_W-1:0]          job_tally,
   output logic                        job_pop,
   input  logic [ipc_pkg::PSNR_W-1:0]  match_threshold,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ipc_pkg::PSNR_W-1:0]  rsp_psnr_db,
   output logic                        rsp_match,
   output logic                        rsp_identical,
   output logic [ipc_pkg::FRAME_W-1:0] rsp_frame_pixels
);
`include "image_psnr_compare_macros.svh"

   localparam int NpixW  = 16 + TALLY_W;
   localparam int LogW   = ipc_pkg::LOG_W;
   localparam int ShW    = ipc_pkg::LOG_SH_W;
   localparam int ResW   = ipc_pkg::LOG_RES_W;
   localparam int MantW  = ipc_pkg::MANT_W;
   localparam int CntW   = ipc_pkg::CNT_W;
   localparam int ProdW  = ipc_pkg::PROD_W;
   localparam int RndSh  = 31 - PSNR_FRAC_BITS;
   localparam int OutSh  = 32 - PSNR_FRAC_BITS;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_NORM  = 7'b0000100,
      ST_FRAC  = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ipc_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [TALLY_W-1:0]          tally_ff, tally_in;
   logic [LogW-1:0]             x_ff, x_in;
   logic [ShW-1:0]              shift_ff, shift_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic                        op_ff, op_in;
   logic [MantW-1:0]            m_ff, m_in;
   logic [ResW-1:0]             res_ff, res_in;
   logic [ResW-1:0]             logn_ff, logn_in;
   logic [ProdW-1:0]            prod_ff, prod_in;
   logic [ipc_pkg::PSNR_W-1:0]  psnr_ff, psnr_in;
   logic                        ident_ff, ident_in;
   logic [ipc_pkg::PSNR_W-1:0]  rsp_psnr_ff, rsp_psnr_in;
   logic                        rsp_match_ff, rsp_match_in;
   logic                        rsp_ident_ff, rsp_ident_in;
   logic [ipc_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;

   logic [NpixW-1:0]  npix;
   logic [ShW:0]      amt;
   logic [LogW-1:0]   top;
   logic [LogW-1:0]   xn;
   logic [ShW-1:0]    shn;
   logic [2*MantW-1:0] sq;
   logic [MantW:0]    t;
   logic [ResW-1:0]   res_nx;
   logic [MantW-1:0]  m_nx;
   logic signed [ResW:0] dl;
   logic [ProdW-1:0]  p_rnd;
   logic [ProdW-1:0]  p_out;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      x_in         = x_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      m_in         = m_ff;
      res_in       = res_ff;
      logn_in      = logn_ff;
      prod_in      = prod_ff;
      psnr_in      = psnr_ff;
      ident_in     = ident_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_psnr_in  = rsp_psnr_ff;
      rsp_match_in = rsp_match_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_frame_in = rsp_frame_ff;
      job_pop      = 1'b0;

      npix = NpixW'(ipc_pkg::PEAK_SQ) * NpixW'(tally_ff);

      // one binary-search step of the leading-zero normalize
      amt = (ShW + 1)'(1) << cnt_ff[2:0];
      top = x_ff >> ((ShW + 1)'(LogW) - amt);
      if (top == '0) begin
         xn  = x_ff << amt;
         shn = shift_ff + amt[ShW-1:0];
      end else begin
         xn  = x_ff;
         shn = shift_ff;
      end

      // one squaring step: mantissa in Q30, range [1,2)
      sq = (2*MantW)'(m_ff) * (2*MantW)'(m_ff);
      t  = sq[2*MantW-1:MantW-1];
      if (t[MantW]) begin
         res_nx = res_ff | (ResW'(1) << cnt_ff);
         m_nx   = t[MantW:1];
      end else begin
         res_nx = res_ff;
         m_nx   = t[MantW-1:0];
      end

      dl    = $signed({1'b0, logn_ff}) - $signed({1'b0, res_ff});
      p_rnd = prod_ff + (ProdW'(1) << RndSh);
      p_out = p_rnd >> OutSh;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               sum_in   = job_sum;
               tally_in = job_tally;
               if (job_sum == '0) begin
                  psnr_in  = '1;
                  ident_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  ident_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            x_in     = LogW'(npix);
            shift_in = '0;
            cnt_in   = CntW'(ipc_pkg::NORM_STEPS - 1);
            op_in    = 1'b0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            x_in     = xn;
            shift_in = shn;
            if (cnt_ff == '0) begin
               m_in     = xn[LogW-1 -: MantW];
               res_in   = {~shn, {ipc_pkg::LOG_FRAC{1'b0}}};
               cnt_in   = CntW'(ipc_pkg::LOG_FRAC - 1);
               state_in = ST_FRAC;
            end else begin
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         ST_FRAC: begin
            m_in   = m_nx;
            res_in = res_nx;
            if (cnt_ff == '0) begin
               if (!op_ff) begin
                  logn_in  = res_nx;
                  op_in    = 1'b1;
                  x_in     = LogW'(sum_ff);
                  shift_in = '0;
                  cnt_in   = CntW'(ipc_pkg::NORM_STEPS - 1);
                  state_in = ST_NORM;
               end else begin
                  state_in = ST_SCALE;
               end
            end else begin
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         ST_SCALE: begin
            if (dl[ResW] || (dl == '0)) begin
               psnr_in  = '0;
               state_in = ST_DONE;
            end else begin
               prod_in  = ProdW'(dl[ResW-1:0]) * ProdW'(ipc_pkg::TEN_LOG10_2);
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            psnr_in  = (p_out > ProdW'({ipc_pkg::PSNR_W{1'b1}})) ? '1
                       : p_out[ipc_pkg::PSNR_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_psnr_in  = psnr_ff;
               rsp_match_in = psnr_ff > match_threshold;
               rsp_ident_in = ident_ff;
               rsp_frame_in = ipc_pkg::FRAME_W'(tally_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      tally_ff     <= tally_in;
      x_ff         <= x_in;
      shift_ff     <= shift_in;
      cnt_ff       <= cnt_in;
      op_ff        <= op_in;
      m_ff         <= m_in;
      res_ff       <= res_in;
      logn_ff      <= logn_in;
      prod_ff      <= prod_in;
      psnr_ff      <= psnr_in;
      ident_ff     <= ident_in;
      rsp_psnr_ff  <= rsp_psnr_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_psnr_db      = rsp_psnr_ff;
   assign rsp_match        = rsp_match_ff;
   assign rsp_identical    = rsp_ident_ff;
   assign rsp_frame_pixels = rsp_frame_ff;

   `IPC_ASSERT_NOW(a_ident_sat, clock, reset, rsp_valid_ff && rsp_ident_ff,
                   rsp_psnr_ff == {ipc_pkg::PSNR_W{1'b1}})
   `IPC_ASSERT_NOW(a_mant_norm, clock, reset, state_ff == ST_FRAC, m_ff[MantW-1])

endmodule
